### sv/nfha_pkg.sv
package nfha_pkg;

  localparam int FUNC_W  = 2;
  localparam int TAG_W   = 16;
  localparam int SIZE_W  = 14;
  localparam int DISP_W  = 32;
  localparam int WHERE_W = 13;
  localparam int STAT_W  = 2;
  localparam int ADDR_W  = 14;
  localparam int CUR_W   = 18;

  localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FREE    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_SCAN    = 2'd3;

  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOFIT   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_INVALID = 2'd2;

  localparam logic [2:0] RES_BAD     = 3'd0;
  localparam logic [2:0] RES_FAIL    = 3'd1;
  localparam logic [2:0] RES_END     = 3'd2;
  localparam logic [2:0] RES_LIVE    = 3'd3;
  localparam logic [2:0] RES_ALLOC   = 3'd4;
  localparam logic [2:0] RES_FREE    = 3'd5;
  localparam logic [2:0] RES_RESTART = 3'd6;

  typedef struct packed {
    logic       in_ready;
    logic       latch;
    logic       init_alloc;
    logic       init_scan;
    logic       rd;
    logic       alloc_step;
    logic       scan_adv;
    logic       wr_rem;
    logic       wr_chunk;
    logic       do_free;
    logic       do_restart;
    logic       set_res;
    logic [2:0] res_sel;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic              in_valid;
    logic [FUNC_W-1:0] func;
    logic              alloc_bad;
    logic              where_bad;
    logic              cur_in;
    logic              tag_nz;
    logic              size_zero;
    logic              step_brk;
    logic              fail;
    logic              split;
    logic              out_busy;
  } st_t;

endpackage

### sv/nfha_req_if.sv
interface nfha_req_if import nfha_pkg::*;;
  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [TAG_W-1:0]   obj_tag;
  logic [SIZE_W-1:0]  size_units;
  logic [DISP_W-1:0]  dispatch_ref;
  logic [WHERE_W-1:0] where;

  modport source (output valid, func, obj_tag, size_units, dispatch_ref, where, input ready);
  modport sink (input valid, func, obj_tag, size_units, dispatch_ref, where, output ready);
endinterface

### sv/nfha_rsp_if.sv
interface nfha_rsp_if import nfha_pkg::*;;
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [ADDR_W-1:0] result_addr;
  logic [SIZE_W-1:0] granted_units;

  modport source (output valid, status, result_addr, granted_units, input ready);
  modport sink (input valid, status, result_addr, granted_units, output ready);
endinterface

### sv/nfha_ctrl.sv
module nfha_ctrl import nfha_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  st_t  st,
  output cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_EV   = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;
  localparam logic [2:0] S_WC   = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (st.in_valid) begin
          cmd.latch = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        unique case (st.func)
          FUNC_ALLOC: begin
            if (st.alloc_bad) begin
              cmd.set_res = 1'b1;
              cmd.res_sel = RES_BAD;
              state_next = S_DONE;
            end else begin
              cmd.init_alloc = 1'b1;
              state_next = S_RD;
            end
          end
          FUNC_SCAN: begin
            cmd.init_scan = 1'b1;
            state_next = S_RD;
          end
          FUNC_FREE: begin
            cmd.set_res = 1'b1;
            if (st.where_bad) begin
              cmd.res_sel = RES_BAD;
            end else begin
              cmd.do_free = 1'b1;
              cmd.res_sel = RES_FREE;
            end
            state_next = S_DONE;
          end
          default: begin
            cmd.set_res = 1'b1;
            if (st.where_bad) begin
              cmd.res_sel = RES_BAD;
            end else begin
              cmd.do_restart = 1'b1;
              cmd.res_sel = RES_RESTART;
            end
            state_next = S_DONE;
          end
        endcase
      end
      S_RD: begin
        if (st.cur_in) begin
          cmd.rd = 1'b1;
          state_next = S_EV;
        end else if (st.func == FUNC_ALLOC) begin
          state_next = S_FIN;
        end else begin
          cmd.set_res = 1'b1;
          cmd.res_sel = RES_END;
          state_next = S_DONE;
        end
      end
      S_EV: begin
        if (st.func == FUNC_ALLOC) begin
          cmd.alloc_step = 1'b1;
          state_next = st.step_brk ? S_FIN : S_RD;
        end else if (st.tag_nz) begin
          cmd.set_res = 1'b1;
          cmd.res_sel = RES_LIVE;
          state_next = S_DONE;
        end else if (st.size_zero) begin
          cmd.set_res = 1'b1;
          cmd.res_sel = RES_END;
          state_next = S_DONE;
        end else begin
          cmd.scan_adv = 1'b1;
          state_next = S_RD;
        end
      end
      S_FIN: begin
        if (st.fail) begin
          cmd.set_res = 1'b1;
          cmd.res_sel = RES_FAIL;
          state_next = S_DONE;
        end else begin
          cmd.wr_rem = st.split;
          state_next = S_WC;
        end
      end
      S_WC: begin
        cmd.wr_chunk = 1'b1;
        cmd.set_res = 1'b1;
        cmd.res_sel = RES_ALLOC;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!st.out_busy) begin
          cmd.load_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst) cmd.load_out |-> !st.out_busy)
    else $error("result loaded over a word not yet taken");
  a_rd_in_heap: assert property (@(posedge clk) disable iff (rst) cmd.rd |-> st.cur_in)
    else $error("header read beyond heap end");

endmodule

### sv/nfha_dp.sv
module nfha_dp import nfha_pkg::*; #(
  parameter int HEAP_UNITS   = 8192,
  parameter int HEADER_UNITS = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             cmd,
  output st_t              st,
  nfha_req_if.sink         req,
  nfha_rsp_if.source       rsp
);

  localparam int AW = $clog2(HEAP_UNITS);
  localparam logic [CUR_W-1:0]  HEAP_C = CUR_W'(HEAP_UNITS);
  localparam logic [SIZE_W-1:0] HDR_S  = SIZE_W'(HEADER_UNITS);

  logic [TAG_W-1:0]  tag_mem  [HEAP_UNITS];
  logic [SIZE_W-1:0] size_mem [HEAP_UNITS];
  logic [DISP_W-1:0] disp_mem [HEAP_UNITS];
  logic              mark_mem [HEAP_UNITS];

  logic [FUNC_W-1:0]  func;
  logic [TAG_W-1:0]   tag;
  logic [SIZE_W-1:0]  sz;
  logic [DISP_W-1:0]  disp;
  logic [WHERE_W-1:0] wh;
  logic [CUR_W-1:0]   cur;
  logic [CUR_W-1:0]   run;
  logic               have;
  logic [AW-1:0]      chunk;
  logic [SIZE_W-1:0]  csize;
  logic [AW-1:0]      next_pos;
  logic               tag0_init;
  logic               size0_init;
  logic [TAG_W-1:0]   rd_tag;
  logic [SIZE_W-1:0]  rd_size;
  logic               rd_tag0;
  logic               rd_size0;
  logic [STAT_W-1:0]  res_status;
  logic [ADDR_W-1:0]  res_addr;
  logic [SIZE_W-1:0]  res_grant;
  logic               out_valid;

  logic [AW-1:0]      idx;
  logic [AW-1:0]      wh_idx;
  logic [TAG_W-1:0]   eff_tag;
  logic [SIZE_W-1:0]  eff_size;
  logic [CUR_W-1:0]   run_sum;
  logic [CUR_W-1:0]   run_next;
  logic [CUR_W-1:0]   cur_add;
  logic [SIZE_W-1:0]  rem;
  logic               absorb;
  logic [CUR_W-1:0]   split_end;
  logic [SIZE_W-1:0]  grant;
  logic [SIZE_W-1:0]  rsize;
  logic               merge;

  logic               tag_we;
  logic [AW-1:0]      tag_wa;
  logic [TAG_W-1:0]   tag_wd;
  logic               size_we;
  logic [AW-1:0]      size_wa;
  logic [SIZE_W-1:0]  size_wd;
  logic               disp_we;
  logic [AW-1:0]      disp_wa;
  logic [DISP_W-1:0]  disp_wd;
  logic               mark_we;
  logic [AW-1:0]      mark_wa;

  assign idx       = cur[AW-1:0];
  assign wh_idx    = AW'(CUR_W'(wh));
  assign eff_tag   = rd_tag0 ? '0 : rd_tag;
  assign eff_size  = rd_size0 ? SIZE_W'(HEAP_C) : rd_size;
  assign run_sum   = run + CUR_W'(eff_size);
  assign run_next  = (eff_tag != '0) ? run : (!have ? CUR_W'(eff_size) : run_sum);
  assign cur_add   = cur + CUR_W'(eff_size);
  assign merge     = cmd.alloc_step && (eff_tag == '0) && have;
  assign rem       = csize - sz;
  assign absorb    = rem < HDR_S;
  assign split_end = CUR_W'(chunk) + CUR_W'(sz);
  assign grant     = absorb ? csize : sz;
  assign rsize     = SIZE_W'(HEAP_C - CUR_W'(wh));

  assign st.in_valid  = req.valid;
  assign st.func      = func;
  assign st.alloc_bad = (tag == '0) || (sz < HDR_S);
  assign st.where_bad = CUR_W'(wh) >= HEAP_C;
  assign st.cur_in    = cur < HEAP_C;
  assign st.tag_nz    = eff_tag != '0;
  assign st.size_zero = eff_size == '0;
  assign st.step_brk  = (run_next >= CUR_W'(sz)) || (eff_size == '0);
  assign st.fail      = !have || (csize < sz);
  assign st.split     = !absorb && (split_end < HEAP_C);
  assign st.out_busy  = out_valid && !rsp.ready;

  assign req.ready         = cmd.in_ready;
  assign rsp.valid         = out_valid;

  always_comb begin
    tag_we  = cmd.wr_rem || cmd.wr_chunk || cmd.do_free || cmd.do_restart;
    size_we = merge || cmd.wr_rem || cmd.wr_chunk || cmd.do_restart;
    disp_we = cmd.wr_rem || cmd.wr_chunk || cmd.do_restart;
    mark_we = tag_we;
    tag_wd  = cmd.wr_chunk ? tag : '0;
    disp_wd = cmd.wr_chunk ? disp : '0;
    priority if (cmd.wr_rem) begin
      tag_wa  = AW'(split_end);
      size_wd = rem;
    end else if (cmd.wr_chunk) begin
      tag_wa  = chunk;
      size_wd = grant;
    end else if (merge) begin
      tag_wa  = chunk;
      size_wd = run_sum[SIZE_W-1:0];
    end else begin
      tag_wa  = wh_idx;
      size_wd = rsize;
    end
    size_wa = tag_wa;
    disp_wa = tag_wa;
    mark_wa = tag_wa;
  end

  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[tag_wa] <= tag_wd;
    end
    if (cmd.rd) begin
      rd_tag <= tag_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (size_we) begin
      size_mem[size_wa] <= size_wd;
    end
    if (cmd.rd) begin
      rd_size <= size_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (disp_we) begin
      disp_mem[disp_wa] <= disp_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (mark_we) begin
      mark_mem[mark_wa] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag0_init  <= 1'b1;
      size0_init <= 1'b1;
      next_pos   <= '0;
      out_valid  <= 1'b0;
      rd_tag0    <= 1'b0;
      rd_size0   <= 1'b0;
    end else begin
      if (tag_we && (tag_wa == '0)) begin
        tag0_init <= 1'b0;
      end
      if (size_we && (size_wa == '0)) begin
        size0_init <= 1'b0;
      end
      if (cmd.rd) begin
        rd_tag0  <= (idx == '0) && tag0_init;
        rd_size0 <= (idx == '0) && size0_init;
      end
      if (cmd.wr_rem) begin
        next_pos <= AW'(split_end);
      end else if (cmd.do_restart) begin
        next_pos <= wh_idx;
      end else if (cmd.do_free && (wh_idx < next_pos)) begin
        next_pos <= wh_idx;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func <= req.func;
      tag  <= req.obj_tag;
      sz   <= req.size_units;
      disp <= req.dispatch_ref;
      wh   <= req.where;
    end
    if (cmd.init_alloc) begin
      cur  <= CUR_W'(next_pos);
      run  <= '0;
      have <= 1'b0;
    end else if (cmd.init_scan) begin
      cur <= CUR_W'(wh);
    end else if (cmd.scan_adv) begin
      cur <= cur_add;
    end else if (cmd.alloc_step) begin
      cur  <= cur_add;
      run  <= run_next;
      have <= eff_tag == '0;
      if (eff_tag == '0) begin
        if (!have) begin
          chunk <= idx;
          csize <= eff_size;
        end else begin
          csize <= run_sum[SIZE_W-1:0];
        end
      end
    end
    if (cmd.set_res) begin
      unique case (cmd.res_sel)
        RES_BAD: begin
          res_status <= STAT_INVALID;
          res_addr   <= '0;
          res_grant  <= '0;
        end
        RES_FAIL: begin
          res_status <= STAT_NOFIT;
          res_addr   <= '0;
          res_grant  <= '0;
        end
        RES_END: begin
          res_status <= STAT_OK;
          res_addr   <= ADDR_W'(HEAP_C);
          res_grant  <= '0;
        end
        RES_LIVE: begin
          res_status <= STAT_OK;
          res_addr   <= cur[ADDR_W-1:0];
          res_grant  <= eff_size;
        end
        RES_ALLOC: begin
          res_status <= STAT_OK;
          res_addr   <= ADDR_W'(CUR_W'(chunk));
          res_grant  <= grant;
        end
        RES_FREE: begin
          res_status <= STAT_OK;
          res_addr   <= ADDR_W'(wh);
          res_grant  <= '0;
        end
        default: begin
          res_status <= STAT_OK;
          res_addr   <= ADDR_W'(wh);
          res_grant  <= rsize;
        end
      endcase
    end
    if (cmd.load_out) begin
      rsp.status        <= res_status;
      rsp.result_addr   <= res_addr;
      rsp.granted_units <= res_grant;
    end
  end

  a_pos_in_heap: assert property (@(posedge clk) disable iff (rst)
    CUR_W'(next_pos) < HEAP_C)
    else $error("next-fit position left the heap");
  a_valid_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.load_out))
    else $error("result word raised without a load");

endmodule

### sv/next_fit_heap_allocator.sv
// Channel  Dir  Word
// req      in   func, obj_tag, size_units, dispatch_ref, where
// rsp      out  status, result_addr, granted_units
//
// One request at a time; a new request is accepted only once the previous result word is loaded.
// Allocate and next-live walk the heap one chunk header at a time; free and restart do no walk.
// Each header walked costs one read of the tag and size memories.
// Reset is synchronous; entry 0 reads as one free chunk of the whole heap until written.
// A result waiting on rsp stalls only the load of the next result.
module next_fit_heap_allocator import nfha_pkg::*; #(
  parameter int HEAP_UNITS   = 8192,
  parameter int HEADER_UNITS = 4
) (
  input  logic       clk,
  input  logic       rst,
  nfha_req_if.sink   req,
  nfha_rsp_if.source rsp
);

  cmd_t cmd;
  st_t  st;

  nfha_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .cmd (cmd)
  );

  nfha_dp #(
    .HEAP_UNITS   (HEAP_UNITS),
    .HEADER_UNITS (HEADER_UNITS)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .st  (st),
    .req (req),
    .rsp (rsp)
  );

endmodule

### dv/tb_next_fit_heap_allocator.sv
`timescale 1ns / 1ps

module tb_next_fit_heap_allocator;
  import nfha_pkg::*;

  localparam int HEAP = 8192;
  localparam int HDR  = 4;
  localparam int NUM_RANDOM = 1150;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [TAG_W-1:0]   obj_tag;
    logic [SIZE_W-1:0]  size_units;
    logic [DISP_W-1:0]  dispatch_ref;
    logic [WHERE_W-1:0] where;
  } heap_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ADDR_W-1:0] result_addr;
    logic [SIZE_W-1:0] granted_units;
  } heap_rsp_t;

  class heap_scoreboard;
    logic [TAG_W-1:0]  chunk_tag[HEAP];
    logic [SIZE_W-1:0] chunk_size[HEAP];
    logic [DISP_W-1:0] chunk_disp[HEAP];
    logic              chunk_mark[HEAP];
    bit                written[HEAP];
    int                written_q[$];
    int                rover;
    heap_rsp_t         pending_rsp[$];
    int                mismatches;
    int                checked;
    int                n_ok, n_nofit, n_invalid;

    function new();
      for (int i = 0; i < HEAP; i++) begin
        chunk_tag[i] = '0;
        chunk_size[i] = '0;
        chunk_disp[i] = '0;
        chunk_mark[i] = 1'b0;
      end
      set_free(0, HEAP);
      rover = 0;
    endfunction

    function void touch(int a);
      if (!written[a]) begin
        written[a] = 1'b1;
        written_q.push_back(a);
      end
    endfunction

    function void set_free(int a, int sz);
      chunk_tag[a] = '0;
      chunk_size[a] = sz[SIZE_W-1:0];
      chunk_mark[a] = 1'b0;
      chunk_disp[a] = '0;
      touch(a);
    endfunction

    function heap_rsp_t allocate(heap_req_t r);
      heap_rsp_t res;
      int cur, chunk, s, run, rem, sz;
      bit have;
      res = '{STAT_INVALID, '0, '0};
      cur = rover;
      chunk = 0;
      have = 0;
      run = 0;
      sz = r.size_units;
      if (r.obj_tag == 0 || sz < HDR) return res;
      while (cur < HEAP) begin
        s = chunk_size[cur];
        if (chunk_tag[cur] != 0) begin
          have = 0;
        end else if (!have) begin
          have = 1;
          chunk = cur;
          run = s;
        end else begin
          run += s;
          chunk_size[chunk] = run[SIZE_W-1:0];
        end
        if (run >= sz) break;
        if (s == 0) break;
        cur += s;
      end
      res.status = STAT_NOFIT;
      if (!have || chunk_size[chunk] < sz) return res;
      run = chunk_size[chunk];
      rem = run - sz;
      if (rem < HDR) begin
        sz = run;
      end else if (chunk + sz < HEAP) begin
        set_free(chunk + sz, rem);
        rover = chunk + sz;
      end
      chunk_mark[chunk] = 1'b0;
      chunk_size[chunk] = sz[SIZE_W-1:0];
      chunk_tag[chunk] = r.obj_tag;
      chunk_disp[chunk] = r.dispatch_ref;
      res = '{STAT_OK, chunk[ADDR_W-1:0], sz[SIZE_W-1:0]};
      return res;
    endfunction

    function void note_request(heap_req_t r);
      heap_rsp_t res;
      int cur, s, w;
      w = r.where;
      case (r.func)
        FUNC_ALLOC: res = allocate(r);
        FUNC_SCAN: begin
          cur = w;
          while (cur < HEAP && chunk_tag[cur] == 0) begin
            s = chunk_size[cur];
            if (s == 0) begin
              cur = HEAP;
              break;
            end
            cur += s;
          end
          if (cur >= HEAP) res = '{STAT_OK, ADDR_W'(HEAP), '0};
          else res = '{STAT_OK, cur[ADDR_W-1:0], chunk_size[cur]};
        end
        FUNC_FREE: begin
          chunk_mark[w] = 1'b0;
          chunk_tag[w] = '0;
          if (w < rover) rover = w;
          res = '{STAT_OK, w[ADDR_W-1:0], '0};
        end
        default: begin
          set_free(w, HEAP - w);
          rover = w;
          s = HEAP - w;
          res = '{STAT_OK, w[ADDR_W-1:0], s[SIZE_W-1:0]};
        end
      endcase
      pending_rsp.push_back(res);
    endfunction

    function void check_result(heap_rsp_t got);
      heap_rsp_t exp;
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected word status=%0d addr=%0d granted=%0d",
                   got.status, got.result_addr, got.granted_units);
        return;
      end
      exp = pending_rsp.pop_front();
      checked++;
      case (exp.status)
        STAT_OK: n_ok++;
        STAT_NOFIT: n_nofit++;
        default: n_invalid++;
      endcase
      if (got !== exp) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: word %0d expected st=%0d addr=%0d g=%0d, got st=%0d addr=%0d g=%0d",
                   checked, exp.status, exp.result_addr, exp.granted_units,
                   got.status, got.result_addr, got.granted_units);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  nfha_req_if req_ch();
  nfha_rsp_if rsp_ch();

  next_fit_heap_allocator DUT (
    .clk(clk),
    .rst(rst),
    .req(req_ch.sink),
    .rsp(rsp_ch.source)
  );

  heap_scoreboard sb = new();
  bit quiet = 1'b0;
  int stall_left = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    req_ch.valid = 1'b0;
    req_ch.func = FUNC_ALLOC;
    req_ch.obj_tag = '0;
    req_ch.size_units = '0;
    req_ch.dispatch_ref = '0;
    req_ch.where = '0;
    rsp_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      sb.check_result('{rsp_ch.status, rsp_ch.result_addr, rsp_ch.granted_units});
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      rsp_ch.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 14);
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  task automatic send(heap_req_t r);
    int gap;
    req_ch.valid <= 1'b1;
    req_ch.func <= r.func;
    req_ch.obj_tag <= r.obj_tag;
    req_ch.size_units <= r.size_units;
    req_ch.dispatch_ref <= r.dispatch_ref;
    req_ch.where <= r.where;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_request(r);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 15);
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic heap_req_t make_req(logic [FUNC_W-1:0] f, int tag, int sz, int w);
    heap_req_t r;
    r.func = f;
    r.obj_tag = tag[TAG_W-1:0];
    r.size_units = sz[SIZE_W-1:0];
    r.dispatch_ref = $urandom();
    r.where = w[WHERE_W-1:0];
    return r;
  endfunction

  function automatic int pick_header(bit want_live);
    int a;
    a = sb.written_q[$urandom_range(0, sb.written_q.size() - 1)];
    for (int i = 0; i < 12 && want_live && sb.chunk_tag[a] == 0; i++)
      a = sb.written_q[$urandom_range(0, sb.written_q.size() - 1)];
    return a;
  endfunction

  function automatic int pick_size();
    int k;
    k = $urandom_range(0, 99);
    if (k < 3) return $urandom_range(0, HDR - 1);
    if (k < 80) return $urandom_range(HDR, 40);
    if (k < 96) return $urandom_range(41, 600);
    return $urandom_range(601, HEAP);
  endfunction

  task automatic run_directed();
    send(make_req(FUNC_ALLOC, 0, 16, 0));
    send(make_req(FUNC_ALLOC, 5, 3, 0));
    send(make_req(FUNC_ALLOC, 5, 0, 0));
    send(make_req(FUNC_ALLOC, 16'hFFFF, HEAP, 0));
    send(make_req(FUNC_SCAN, 0, 0, 0));
    send(make_req(FUNC_FREE, 0, 0, 0));
    send(make_req(FUNC_SCAN, 0, 0, 0));
    send(make_req(FUNC_ALLOC, 16'hFFFF, HDR, 0));
    send(make_req(FUNC_ALLOC, 1, 7, 0));
    send(make_req(FUNC_SCAN, 0, 0, 0));
    send(make_req(FUNC_FREE, 0, 0, 0));
    send(make_req(FUNC_ALLOC, 2, 12, 0));
    send(make_req(FUNC_RESTART, 0, 0, 0));
    send(make_req(FUNC_ALLOC, 3, HEAP - 2, 0));
    send(make_req(FUNC_FREE, 0, 0, 0));
    send(make_req(FUNC_RESTART, 0, 0, HEAP - 1));
    send(make_req(FUNC_ALLOC, 4, HDR, 0));
    send(make_req(FUNC_RESTART, 0, 0, 100));
    send(make_req(FUNC_ALLOC, 4, 8100, 0));
    send(make_req(FUNC_SCAN, 0, 0, 100));
    send(make_req(FUNC_RESTART, 0, 0, 0));
  endtask

  task automatic run_random();
    int k;
    heap_req_t r;
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n > NUM_RANDOM * 9 / 10) quiet = 1'b1;
      k = $urandom_range(0, 99);
      if (k < 50) begin
        r = make_req(FUNC_ALLOC, ($urandom_range(0, 32) == 0) ? 0 : $urandom_range(1, 65535),
                     pick_size(), $urandom());
      end else if (k < 78) begin
        r = make_req(FUNC_FREE, $urandom(), $urandom(), pick_header(1'b1));
      end else if (k < 94) begin
        r = make_req(FUNC_SCAN, $urandom(), $urandom(), pick_header(1'b0));
      end else begin
        r = make_req(FUNC_RESTART, $urandom(), $urandom(),
                     ($urandom_range(0, 1) == 0) ? $urandom_range(0, HEAP - 1)
                                                 : $urandom_range(0, 255));
      end
      send(r);
    end
    req_ch.valid <= 1'b0;
  endtask

  initial begin
    int waited;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    run_random();
    waited = 0;
    while (sb.pending_rsp.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (40) @(posedge clk);
    $display("Checked %0d results: %0d ok, %0d no-fit, %0d invalid; %0d headers touched.",
             sb.checked, sb.n_ok, sb.n_nofit, sb.n_invalid, sb.written_q.size());
    if (sb.mismatches == 0 && sb.pending_rsp.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending_rsp.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #100000000;
    $display("Timeout with %0d results outstanding", sb.pending_rsp.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
